// ===== sv/dws_pkg.sv =====
// Shared types and codes for the deque with search.
package dws_pkg;

  localparam logic [1:0] KIND_APPEND     = 2'd0;
  localparam logic [1:0] KIND_POP_OLDEST = 2'd1;
  localparam logic [1:0] KIND_POP_NEWEST = 2'd2;
  localparam logic [1:0] KIND_SEARCH     = 2'd3;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  localparam int FillW = 7;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] item_value;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [FillW-1:0] fill_count;
    logic             found;
  } rsp_t;

endpackage

// ===== sv/deque_with_search_core.sv =====
// Bounded double-ended queue in a ring memory with a sequential value search.
//
//   channel   signals                 handshake
//   request   start, busy, req        accepted when start && !busy
//   result    done, result            one cycle per strobe, no back-pressure
//
// Append and removals: result in the cycle after acceptance; busy stays low, so a
// new request can be accepted every cycle.
// Search: busy until the scan ends; one memory read per cycle feeds a
// single 32-bit comparator, and the scan stops at the first match.
// Reset (rst, synchronous) empties the queue; memory contents are not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
module deque_with_search_core #(
  parameter int DEPTH = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  dws_pkg::req_t  req,
  output logic           done,
  output dws_pkg::rsp_t  result
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [IW-1:0] LastIdx = IW'(DEPTH - 1);
  localparam logic [CW-1:0] FullCnt = CW'(DEPTH);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic              state, state_next;
  logic [IW-1:0]     head, head_next;
  logic [IW-1:0]     tail, tail_next;
  logic [CW-1:0]     cnt, cnt_next;
  logic [IW-1:0]     ptr, ptr_next;
  logic [CW-1:0]     issued, issued_next;
  logic              rd_valid, rd_valid_next;
  logic              rd_en;
  logic [31:0]       rd_data;
  logic [31:0]       key;
  logic              done_next;
  dws_pkg::rsp_t     result_next;
  logic              mem_we;
  logic              accept;
  logic [31:0]       mem [DEPTH];

  assign accept = start && !busy;
  assign busy   = (state == S_SCAN);

  function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] i);
    ring_next = (i == LastIdx) ? '0 : i + IW'(1);
  endfunction

  function automatic logic [IW-1:0] ring_prev(input logic [IW-1:0] i);
    ring_prev = (i == '0) ? LastIdx : i - IW'(1);
  endfunction

  always_comb begin
    state_next    = state;
    head_next     = head;
    tail_next     = tail;
    cnt_next      = cnt;
    ptr_next      = ptr;
    issued_next   = issued;
    rd_valid_next = 1'b0;
    rd_en         = 1'b0;
    mem_we        = 1'b0;
    done_next     = 1'b0;
    result_next   = result;
    case (state)
      S_IDLE: begin
        if (accept) begin
          result_next.status = dws_pkg::STATUS_OK;
          result_next.found  = 1'b0;
          done_next          = 1'b1;
          case (req.kind)
            dws_pkg::KIND_APPEND: begin
              if (cnt == FullCnt) begin
                result_next.status = dws_pkg::STATUS_FULL;
              end else begin
                mem_we    = 1'b1;
                tail_next = ring_next(tail);
                cnt_next  = cnt + CW'(1);
              end
            end
            dws_pkg::KIND_POP_OLDEST: begin
              if (cnt == '0) begin
                result_next.status = dws_pkg::STATUS_EMPTY;
              end else begin
                head_next = ring_next(head);
                cnt_next  = cnt - CW'(1);
              end
            end
            dws_pkg::KIND_POP_NEWEST: begin
              if (cnt == '0) begin
                result_next.status = dws_pkg::STATUS_EMPTY;
              end else begin
                tail_next = ring_prev(tail);
                cnt_next  = cnt - CW'(1);
              end
            end
            default: begin
              done_next   = 1'b0;
              state_next  = S_SCAN;
              ptr_next    = head;
              issued_next = '0;
            end
          endcase
          result_next.fill_count = dws_pkg::FillW'(cnt_next);
        end
      end
      S_SCAN: begin
        if (rd_valid && rd_data == key) begin
          done_next          = 1'b1;
          result_next.status = dws_pkg::STATUS_OK;
          result_next.found  = 1'b1;
          result_next.fill_count = dws_pkg::FillW'(cnt);
          state_next         = S_IDLE;
        end else if (issued == cnt && !rd_valid) begin
          done_next          = 1'b1;
          result_next.status = dws_pkg::STATUS_OK;
          result_next.found  = 1'b0;
          result_next.fill_count = dws_pkg::FillW'(cnt);
          state_next         = S_IDLE;
        end else if (issued != cnt) begin
          rd_en         = 1'b1;
          rd_valid_next = 1'b1;
          ptr_next      = ring_next(ptr);
          issued_next   = issued + CW'(1);
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      head     <= '0;
      tail     <= '0;
      cnt      <= '0;
      rd_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      head     <= head_next;
      tail     <= tail_next;
      cnt      <= cnt_next;
      rd_valid <= rd_valid_next;
      done     <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    ptr    <= ptr_next;
    issued <= issued_next;
    result <= result_next;
    if (accept) begin
      key <= req.item_value;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[tail] <= req.item_value;
    end
    if (rd_en) begin
      rd_data <= mem[ptr];
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt <= FullCnt)
    else $error("entry count above depth");

  a_search_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && req.kind == dws_pkg::KIND_SEARCH) |=> (busy && !done))
    else $error("search transaction did not start a scan");

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while scan still running");

  a_fill_match: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.fill_count == dws_pkg::FillW'(cnt)))
    else $error("reported fill count differs from held count");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> (issued <= cnt))
    else $error("scan read past held entries");

endmodule
